### rtl/psr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke resampler package
// Widths, register reset values, microcode opcodes and the control and
// status bundles shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int COORD_W       = 24;
  localparam int STEP_W        = COORD_W + 1;
  localparam int REG_W         = 25;
  localparam int ID_W          = 16;
  localparam int CFG_IDX_W     = 3;
  // Scaled difference magnitude: up to three times a coordinate difference.
  localparam int MAG_W         = COORD_W + 2;
  localparam int PC_W          = 5;

  // Division by three as a multiply by the rounded-up reciprocal. Exact for
  // every dividend below 2**DIV3_SHIFT.
  localparam int DIV3_SHIFT = MAG_W + 1;
  localparam logic [MAG_W-1:0] DIV3_MAGIC = (MAG_W)'(((64'd1 << DIV3_SHIFT) / 3) + 1);

  localparam logic [REG_W-1:0] MIN_STEP_RST  = (REG_W)'(2 << FRACTION_BITS);
  localparam logic [REG_W-1:0] MAX_JUMP_RST  = (REG_W)'(600 << FRACTION_BITS);
  localparam logic [REG_W-1:0] NEAR_DIST_RST = (REG_W)'(3 << FRACTION_BITS);
  localparam logic [REG_W-1:0] MID_DIST_RST  = (REG_W)'(6 << FRACTION_BITS);
  localparam logic [REG_W-1:0] FAR_DIST_RST  = (REG_W)'(12 << FRACTION_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DIST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_DIST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_DIST  = 3'd4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [PC_W-1:0]    upc_t;
  typedef logic [2:0]         nseg_t;
  typedef logic [1:0]         segi_t;

  localparam nseg_t NSEG_2 = 3'd2;
  localparam nseg_t NSEG_3 = 3'd3;
  localparam nseg_t NSEG_4 = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_STEP,
    OP_SETSEG,
    OP_TDIFF,
    OP_DIV,
    OP_TADD,
    OP_NDIFF,
    OP_NADD,
    OP_EMITN,
    OP_EMITS,
    OP_EMIT_FIRST,
    OP_EMIT_DIRECT,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_END_IDLE,
    C_NOT_STARTED,
    C_DROP,
    C_NEAR,
    C_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic in_fire;
  } ctrl_t;

  typedef struct packed {
    logic final_pt;
    logic started;
    logic drop;
    logic near;
    logic more;
    logic stall;
  } stat_t;

endpackage

### rtl/psr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke resampler channels
// Sample input, stroke point output and register write channels.
// ----------------------------------------------------------------------------
interface psr_in_if;
  logic            valid;
  logic            ready;
  logic            req_type;
  psr_pkg::coord_t pen_x;
  psr_pkg::coord_t pen_y;

  modport source (output valid, req_type, pen_x, pen_y, input ready);
  modport sink (input valid, req_type, pen_x, pen_y, output ready);
endinterface

interface psr_out_if;
  logic                     valid;
  logic                     ready;
  psr_pkg::coord_t          out_x;
  psr_pkg::coord_t          out_y;
  logic [psr_pkg::ID_W-1:0] stroke_id;
  logic                     last_of_run;

  modport source (output valid, out_x, out_y, stroke_id, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, stroke_id, last_of_run, output ready);
endinterface

interface psr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [psr_pkg::CFG_IDX_W-1:0] index;
  logic [psr_pkg::REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/psr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke resampler sequencer
// Micro-program counter and control store; issues one control word a cycle
// and holds while the datapath waits for room at the output.
// ----------------------------------------------------------------------------
module psr_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psr_pkg::stat_t  stat,
  output psr_pkg::ctrl_t  ctrl
);

  localparam psr_pkg::upc_t UA_IDLE      = 5'd0;
  localparam psr_pkg::upc_t UA_CHK_END   = 5'd1;
  localparam psr_pkg::upc_t UA_CHK_NEW   = 5'd2;
  localparam psr_pkg::upc_t UA_STEP      = 5'd3;
  localparam psr_pkg::upc_t UA_CLASS     = 5'd4;
  localparam psr_pkg::upc_t UA_CHK_NEAR  = 5'd5;
  localparam psr_pkg::upc_t UA_LOOP      = 5'd6;
  localparam psr_pkg::upc_t UA_DIVT      = 5'd7;
  localparam psr_pkg::upc_t UA_TADD      = 5'd8;
  localparam psr_pkg::upc_t UA_NDIFF     = 5'd9;
  localparam psr_pkg::upc_t UA_DIVN      = 5'd10;
  localparam psr_pkg::upc_t UA_NADD      = 5'd11;
  localparam psr_pkg::upc_t UA_EMITN     = 5'd12;
  localparam psr_pkg::upc_t UA_EMITS     = 5'd13;
  localparam psr_pkg::upc_t UA_FIRST     = 5'd14;
  localparam psr_pkg::upc_t UA_DIRECT    = 5'd15;
  localparam psr_pkg::upc_t UA_FIN       = 5'd16;

  psr_pkg::upc_t   upc;
  psr_pkg::upc_t   upc_next;
  psr_pkg::uword_t uw;
  logic            in_fire;
  logic            jump;

  // Control store.
  always_comb begin
    case (upc)
      UA_IDLE:     uw = '{psr_pkg::OP_LOAD,        psr_pkg::C_NO_INPUT,    UA_IDLE};
      UA_CHK_END:  uw = '{psr_pkg::OP_NOP,         psr_pkg::C_END_IDLE,    UA_FIN};
      UA_CHK_NEW:  uw = '{psr_pkg::OP_NOP,         psr_pkg::C_NOT_STARTED, UA_FIRST};
      UA_STEP:     uw = '{psr_pkg::OP_STEP,        psr_pkg::C_NEVER,       UA_IDLE};
      UA_CLASS:    uw = '{psr_pkg::OP_SETSEG,      psr_pkg::C_DROP,        UA_FIN};
      UA_CHK_NEAR: uw = '{psr_pkg::OP_NOP,         psr_pkg::C_NEAR,        UA_DIRECT};
      UA_LOOP:     uw = '{psr_pkg::OP_TDIFF,       psr_pkg::C_NEVER,       UA_IDLE};
      UA_DIVT:     uw = '{psr_pkg::OP_DIV,         psr_pkg::C_NEVER,       UA_IDLE};
      UA_TADD:     uw = '{psr_pkg::OP_TADD,        psr_pkg::C_NEVER,       UA_IDLE};
      UA_NDIFF:    uw = '{psr_pkg::OP_NDIFF,       psr_pkg::C_NEVER,       UA_IDLE};
      UA_DIVN:     uw = '{psr_pkg::OP_DIV,         psr_pkg::C_NEVER,       UA_IDLE};
      UA_NADD:     uw = '{psr_pkg::OP_NADD,        psr_pkg::C_NEVER,       UA_IDLE};
      UA_EMITN:    uw = '{psr_pkg::OP_EMITN,       psr_pkg::C_MORE,        UA_LOOP};
      UA_EMITS:    uw = '{psr_pkg::OP_EMITS,       psr_pkg::C_ALWAYS,      UA_FIN};
      UA_FIRST:    uw = '{psr_pkg::OP_EMIT_FIRST,  psr_pkg::C_ALWAYS,      UA_FIN};
      UA_DIRECT:   uw = '{psr_pkg::OP_EMIT_DIRECT, psr_pkg::C_ALWAYS,      UA_FIN};
      UA_FIN:      uw = '{psr_pkg::OP_FINISH,      psr_pkg::C_ALWAYS,      UA_IDLE};
      default:     uw = '{psr_pkg::OP_NOP,         psr_pkg::C_ALWAYS,      UA_IDLE};
    endcase
  end

  assign in_ready = (upc == UA_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    case (uw.cond)
      psr_pkg::C_NEVER:       jump = 1'b0;
      psr_pkg::C_ALWAYS:      jump = 1'b1;
      psr_pkg::C_NO_INPUT:    jump = !in_fire;
      psr_pkg::C_END_IDLE:    jump = stat.final_pt && !stat.started;
      psr_pkg::C_NOT_STARTED: jump = !stat.started;
      psr_pkg::C_DROP:        jump = stat.drop;
      psr_pkg::C_NEAR:        jump = stat.near;
      psr_pkg::C_MORE:        jump = stat.more;
      default:                jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stat.stall) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  assign ctrl.op      = uw.op;
  assign ctrl.in_fire = in_fire;

endmodule

### rtl/psr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke resampler segment divider
// Registered quotient of a magnitude by the segment count (2, 3 or 4).
// ----------------------------------------------------------------------------
module psr_div (
  input  logic                        clk,
  input  logic                        en,
  input  psr_pkg::nseg_t              nseg,
  input  logic [psr_pkg::MAG_W-1:0]   mag,
  output psr_pkg::coord_t             quo
);

  logic [2*psr_pkg::MAG_W-1:0] prod;
  logic [psr_pkg::MAG_W-1:0]   q_next;

  assign prod = (2 * psr_pkg::MAG_W)'(mag) * (2 * psr_pkg::MAG_W)'(psr_pkg::DIV3_MAGIC);

  always_comb begin
    case (nseg)
      psr_pkg::NSEG_2: q_next = mag >> 1;
      psr_pkg::NSEG_4: q_next = mag >> 2;
      default:         q_next = (psr_pkg::MAG_W)'(prod >> psr_pkg::DIV3_SHIFT);
    endcase
  end

  // The quotient is always below the coordinate range, since the scale
  // factor is smaller than the segment count.
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= (psr_pkg::COORD_W)'(q_next);
    end
  end

endmodule

### rtl/psr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke resampler datapath
// Registers, step classifier, interpolation arithmetic, pending point and
// output register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module psr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  psr_pkg::ctrl_t                ctrl,
  output psr_pkg::stat_t                stat,
  input  logic                          req_type,
  input  psr_pkg::coord_t               pen_x,
  input  psr_pkg::coord_t               pen_y,
  input  logic                          cfg_fire,
  input  logic [psr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psr_pkg::REG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output psr_pkg::coord_t               out_x,
  output psr_pkg::coord_t               out_y,
  output logic [psr_pkg::ID_W-1:0]      stroke_id,
  output logic                          last_of_run
);

  logic [psr_pkg::REG_W-1:0] min_step, max_jump, near_dist, mid_dist, far_dist;

  psr_pkg::coord_t            last_x, last_y, prev_x, prev_y;
  psr_pkg::coord_t            sx, sy;
  psr_pkg::coord_t            t_x, t_y, n_x, n_y;
  psr_pkg::coord_t            q_x, q_y;
  logic                       started;
  logic [psr_pkg::ID_W-1:0]   stroke_number;
  logic                       final_pt;
  logic [psr_pkg::STEP_W-1:0] step;
  psr_pkg::nseg_t             nseg;
  psr_pkg::segi_t             seg_i;
  logic [psr_pkg::MAG_W-1:0]  mag_x, mag_y;
  logic                       neg_x, neg_y;

  logic                       pend_valid;
  psr_pkg::coord_t            pend_x, pend_y;
  logic [psr_pkg::ID_W-1:0]   pend_id;

  logic            lt_min, gt_max, lt_near, lt_mid, ge_far;
  logic            n_diff, s_diff;
  logic            emit_en, flush, need_slot, stall, go, push;
  psr_pkg::coord_t emit_x, emit_y;

  function automatic psr_pkg::coord_t abs_diff(psr_pkg::coord_t a, psr_pkg::coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [psr_pkg::MAG_W-1:0] scale_by(psr_pkg::coord_t v,
                                                         psr_pkg::segi_t k);
    logic [psr_pkg::MAG_W-1:0] w;
    w = (psr_pkg::MAG_W)'(v);
    case (k)
      2'd2:    scale_by = w << 1;
      2'd3:    scale_by = w + (w << 1);
      default: scale_by = w;
    endcase
  endfunction

  psr_div u_div_x (
    .clk  (clk),
    .en   (ctrl.op == psr_pkg::OP_DIV),
    .nseg (nseg),
    .mag  (mag_x),
    .quo  (q_x)
  );

  psr_div u_div_y (
    .clk  (clk),
    .en   (ctrl.op == psr_pkg::OP_DIV),
    .nseg (nseg),
    .mag  (mag_y),
    .quo  (q_y)
  );

  // Step classification against the limits, in the order they are applied.
  assign lt_min  = step < min_step;
  assign gt_max  = step > max_jump;
  assign lt_near = step < near_dist;
  assign lt_mid  = step < mid_dist;
  assign ge_far  = step >= far_dist;

  assign n_diff = (n_x != last_x) || (n_y != last_y);
  assign s_diff = (sx != last_x) || (sy != last_y);

  always_comb begin
    case (ctrl.op)
      psr_pkg::OP_EMITN:       emit_en = n_diff;
      psr_pkg::OP_EMITS:       emit_en = final_pt && s_diff;
      psr_pkg::OP_EMIT_FIRST:  emit_en = 1'b1;
      psr_pkg::OP_EMIT_DIRECT: emit_en = 1'b1;
      default:                 emit_en = 1'b0;
    endcase
  end

  assign emit_x = (ctrl.op == psr_pkg::OP_EMITN) ? n_x : sx;
  assign emit_y = (ctrl.op == psr_pkg::OP_EMITN) ? n_y : sy;

  // A new point only goes out once the next one, or the end of the
  // transaction, shows whether it is the final one.
  assign flush     = (ctrl.op == psr_pkg::OP_FINISH) && pend_valid;
  assign need_slot = (emit_en && pend_valid) || flush;
  assign stall     = need_slot && out_valid && !out_ready;
  assign go        = !stall;
  assign push      = need_slot && go;

  assign stat.final_pt = final_pt;
  assign stat.started  = started;
  assign stat.drop     = lt_min || gt_max;
  assign stat.near     = lt_near;
  assign stat.more     = (3'(seg_i) + 3'd1) < nseg;
  assign stat.stall    = stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_step  <= psr_pkg::MIN_STEP_RST;
      max_jump  <= psr_pkg::MAX_JUMP_RST;
      near_dist <= psr_pkg::NEAR_DIST_RST;
      mid_dist  <= psr_pkg::MID_DIST_RST;
      far_dist  <= psr_pkg::FAR_DIST_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        psr_pkg::CFG_MIN_STEP:  min_step  <= cfg_data;
        psr_pkg::CFG_MAX_JUMP:  max_jump  <= cfg_data;
        psr_pkg::CFG_NEAR_DIST: near_dist <= cfg_data;
        psr_pkg::CFG_MID_DIST:  mid_dist  <= cfg_data;
        psr_pkg::CFG_FAR_DIST:  far_dist  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stroke state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x        <= '0;
      last_y        <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      started       <= 1'b0;
      stroke_number <= '0;
      final_pt      <= 1'b0;
    end else if (go) begin
      case (ctrl.op)
        psr_pkg::OP_LOAD: begin
          if (ctrl.in_fire) begin
            final_pt <= req_type;
            sx       <= req_type ? prev_x : pen_x;
            sy       <= req_type ? prev_y : pen_y;
          end
        end
        psr_pkg::OP_STEP: begin
          step <= psr_pkg::STEP_W'(abs_diff(sx, last_x)) +
                  psr_pkg::STEP_W'(abs_diff(sy, last_y));
        end
        psr_pkg::OP_SETSEG: begin
          nseg  <= lt_mid ? psr_pkg::NSEG_2 : (ge_far ? psr_pkg::NSEG_4 : psr_pkg::NSEG_3);
          seg_i <= 2'd1;
        end
        psr_pkg::OP_TDIFF: begin
          mag_x <= scale_by(abs_diff(sx, prev_x), seg_i);
          mag_y <= scale_by(abs_diff(sy, prev_y), seg_i);
          neg_x <= sx < prev_x;
          neg_y <= sy < prev_y;
        end
        psr_pkg::OP_TADD: begin
          t_x <= neg_x ? prev_x - q_x : prev_x + q_x;
          t_y <= neg_y ? prev_y - q_y : prev_y + q_y;
        end
        psr_pkg::OP_NDIFF: begin
          mag_x <= (psr_pkg::MAG_W)'(abs_diff(t_x, last_x));
          mag_y <= (psr_pkg::MAG_W)'(abs_diff(t_y, last_y));
          neg_x <= t_x < last_x;
          neg_y <= t_y < last_y;
        end
        psr_pkg::OP_NADD: begin
          n_x <= neg_x ? last_x - q_x : last_x + q_x;
          n_y <= neg_y ? last_y - q_y : last_y + q_y;
        end
        psr_pkg::OP_EMITN: begin
          if (n_diff) begin
            last_x <= n_x;
            last_y <= n_y;
          end
          seg_i <= seg_i + 1'b1;
        end
        psr_pkg::OP_EMITS: begin
          if (final_pt && s_diff) begin
            last_x <= sx;
            last_y <= sy;
          end
          prev_x <= sx;
          prev_y <= sy;
        end
        psr_pkg::OP_EMIT_FIRST: begin
          last_x  <= sx;
          last_y  <= sy;
          prev_x  <= sx;
          prev_y  <= sy;
          started <= 1'b1;
        end
        psr_pkg::OP_EMIT_DIRECT: begin
          last_x <= sx;
          last_y <= sy;
          prev_x <= sx;
          prev_y <= sy;
        end
        psr_pkg::OP_FINISH: begin
          if (final_pt && started) begin
            stroke_number <= stroke_number + 1'b1;
            started       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Pending point and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_en && go) begin
        pend_valid <= 1'b1;
        pend_x     <= emit_x;
        pend_y     <= emit_y;
        pend_id    <= stroke_number;
      end else if (flush && go) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid   <= 1'b1;
        out_x       <= pend_x;
        out_y       <= pend_y;
        stroke_id   <= pend_id;
        last_of_run <= (ctrl.op == psr_pkg::OP_FINISH);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == psr_pkg::OP_LOAD) |-> !pend_valid)
    else $error("point still pending while waiting for a new sample");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == psr_pkg::OP_EMITN) |-> (3'(seg_i) < nseg))
    else $error("interpolation index ran past the segment count");

  a_seg_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == psr_pkg::OP_TDIFF) |->
      (nseg == psr_pkg::NSEG_2 || nseg == psr_pkg::NSEG_3 || nseg == psr_pkg::NSEG_4))
    else $error("segment count out of range in interpolation");

  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == psr_pkg::OP_FINISH && !stall) |=> !pend_valid)
    else $error("pending point left behind at end of transaction");

  a_stroke_closes: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == psr_pkg::OP_FINISH && !stall && final_pt) |=> !started)
    else $error("stroke still open after end of stroke");

endmodule

### rtl/pen_stroke_point_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pen stroke point resampler
// Turns raw pen samples into evenly spaced stroke points under a small
// microcoded sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time is in work: a new sample is taken only when the
// sequencer is back at its first step. Opening a stroke runs the end and
// stroke checks and the emit step; a dropped sample also runs the step and
// class steps, a direct one the near check too, and a split one (2, 3 or 4
// segments) then walks each intermediate point through the same per-axis
// subtract, divide and add logic in seven microcode steps. An end of stroke
// with no stroke open runs only the end check and the finish step; with a
// stroke open it takes the same paths as a sample. The sequencer holds while
// the output is full. The result register lets the last point of a
// transaction wait while the next sample is taken. Registers may be written
// at any time the block is idle; the write channel is always ready.
// ----------------------------------------------------------------------------
module pen_stroke_point_resampler (
  input  logic        clk,
  input  logic        rst,
  psr_in_if.sink      samp,
  psr_out_if.source   pts,
  psr_cfg_if.sink     cfg
);

  psr_pkg::ctrl_t ctrl;
  psr_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  psr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samp.valid),
    .in_ready (samp.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  psr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .req_type    (samp.req_type),
    .pen_x       (samp.pen_x),
    .pen_y       (samp.pen_y),
    .cfg_fire    (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_valid   (pts.valid),
    .out_ready   (pts.ready),
    .out_x       (pts.out_x),
    .out_y       (pts.out_y),
    .stroke_id   (pts.stroke_id),
    .last_of_run (pts.last_of_run)
  );

endmodule
